[rtl/clbws_pkg.sv]
// ----------------------------------------------------------------------------
// clbws_pkg
// shared types and constants of the character lcd bus write sequencer
// ----------------------------------------------------------------------------
package clbws_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int MAX_COLUMN_DEF = 39;

  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_CURSOR = 2'd2;
  localparam logic [1:0] REQ_NUMBER = 2'd3;

  localparam logic [7:0] DDRAM_LINE0 = 8'h80;
  localparam logic [7:0] DDRAM_LINE1 = 8'hC0;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;

  // n / 10 == (n * RECIP) >> 35 for every 32-bit n
  localparam logic [31:0] DIV10_RECIP = 32'hCCCCCCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          QUOT_W      = 64 - DIV10_SHIFT;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [3:0]  rem;
  } div10_res_t;

endpackage

[rtl/char_lcd_bus_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_bus_write_sequencer
// turns lcd requests into command and data writes on a 4-bit or 8-bit bus
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one request item (req_type,
// byte_value, line, column, number_value); in_stall is high while a request
// is being worked, so one request is handled at a time.
// output channel: out_valid / out_stall carry one bus write item each, held
// in an output register; the next request is taken while the final item of
// the previous one still waits there.
// cfg_we / cfg_data set four_bit_mode (reset value 1); write it only while idle.
// sequence: a command, data or cursor move is taken in idle, then sent at
// one bus write per cycle (1 or 2) unless the receiver stalls. a cursor
// move out of range gives one error item. a number is split into digits,
// one at a time, through the one divide-by-ten unit, reused for each digit
// (multiply, remainder, store); then each digit is loaded and sent at one
// bus write per cycle. a stalled receiver holds the output register and the
// sequencer waits on it. reset (rst, synchronous) empties the output register
// and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module char_lcd_bus_write_sequencer
  import clbws_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_COLUMN = MAX_COLUMN_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  byte_value,
  input  logic [1:0]  line,
  input  logic [5:0]  column,
  input  logic [31:0] number_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  bus_value,
  output logic        register_select,
  output logic        write_valid,
  output logic        range_error,
  output logic        last
);

  localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEND  = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_DIVGO = 3'd3;
  localparam logic [2:0] ST_DIVWT = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;

  logic [2:0]       state;
  logic             four_bit_mode;
  logic             phase;
  logic             digit_mode;
  logic [7:0]       cur_byte;
  logic             cur_rs;
  logic [31:0]      num;
  logic [DIG_W-1:0] ndig;
  logic [DIG_W-1:0] idx;
  logic [3:0]       digits [MAX_DIGITS];

  logic       accept;
  logic       out_ok;
  logic       out_load;
  logic       div_start;
  div10_res_t div_res;
  logic       bad_cursor;
  logic [7:0] cursor_cmd;
  logic       more_digits;

  clbws_div10 u_div10 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .res      (div_res)
  );

  always_comb begin
    in_stall    = (state != ST_IDLE);
    accept      = in_valid && !in_stall;
    out_ok      = !out_valid || !out_stall;
    out_load    = out_ok && ((state == ST_SEND) || (state == ST_ERR));
    div_start   = (state == ST_DIVGO);
    bad_cursor  = (line > 2'd1) || (column > 6'(MAX_COLUMN));
    cursor_cmd  = ((line == 2'd0) ? DDRAM_LINE0 : DDRAM_LINE1) + 8'(column);
    more_digits = digit_mode && (idx != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b1;
    end else if (cfg_we) begin
      four_bit_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase      <= 1'b0;
            digit_mode <= 1'b0;
            num        <= number_value;
            ndig       <= '0;
            case (req_type)
              REQ_CMD: begin
                cur_byte <= byte_value;
                cur_rs   <= 1'b0;
                state    <= ST_SEND;
              end
              REQ_DATA: begin
                cur_byte <= byte_value;
                cur_rs   <= 1'b1;
                state    <= ST_SEND;
              end
              REQ_CURSOR: begin
                cur_byte <= cursor_cmd;
                cur_rs   <= 1'b0;
                state    <= bad_cursor ? ST_ERR : ST_SEND;
              end
              default: begin
                digit_mode <= 1'b1;
                cur_rs     <= 1'b1;
                state      <= ST_DIVGO;
              end
            endcase
          end
        end
        ST_SEND: begin
          if (out_ok) begin
            register_select <= cur_rs;
            write_valid     <= 1'b1;
            range_error     <= 1'b0;
            if (four_bit_mode && !phase) begin
              bus_value <= {4'h0, cur_byte[7:4]};
              last      <= 1'b0;
              phase     <= 1'b1;
            end else begin
              bus_value <= four_bit_mode ? {4'h0, cur_byte[3:0]} : cur_byte;
              last      <= !more_digits;
              phase     <= 1'b0;
              if (more_digits) begin
                idx   <= idx - DIG_W'(1);
                state <= ST_LOAD;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_ERR: begin
          if (out_ok) begin
            bus_value       <= 8'h00;
            register_select <= 1'b0;
            write_valid     <= 1'b0;
            range_error     <= 1'b1;
            last            <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        ST_DIVGO: begin
          state <= ST_DIVWT;
        end
        ST_DIVWT: begin
          if (div_res.done) begin
            digits[ndig] <= div_res.rem;
            num          <= div_res.quot;
            if ((div_res.quot == 32'd0) || (ndig == DIG_W'(MAX_DIGITS - 1))) begin
              idx   <= ndig;
              state <= ST_LOAD;
            end else begin
              ndig  <= ndig + DIG_W'(1);
              state <= ST_DIVGO;
            end
          end
        end
        ST_LOAD: begin
          cur_byte <= ASCII_ZERO + 8'(digits[idx]);
          state    <= ST_SEND;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("sequencer took an item without going busy");

  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (last && !write_valid))
    else $error("range error item is not a lone non-write item");

  a_data_is_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && register_select) |-> write_valid)
    else $error("data select on a non-write item");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIVWT))
    else $error("divide result outside the wait state");

endmodule

[rtl/clbws_div10.sv]
// ----------------------------------------------------------------------------
// clbws_div10
// shared divide-by-ten unit: registered reciprocal multiply, then registered remainder
// ----------------------------------------------------------------------------
module clbws_div10
  import clbws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  output div10_res_t  res
);

  logic        stage1;
  logic [31:0] dvd1;
  logic [63:0] prod1;

  logic [QUOT_W-1:0] quot;
  logic [31:0]       quot_ext;
  logic [31:0]       rem_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
    end else begin
      stage1 <= start;
    end
    dvd1  <= dividend;
    prod1 <= 64'(dividend) * 64'(DIV10_RECIP);
  end

  always_comb begin
    quot     = prod1[63:DIV10_SHIFT];
    quot_ext = 32'(quot);
    rem_full = dvd1 - ((quot_ext << 3) + (quot_ext << 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.done <= 1'b0;
    end else begin
      res.done <= stage1;
    end
    res.quot <= quot_ext;
    res.rem  <= rem_full[3:0];
  end

endmodule
